@@ rtl/core/rcpc_pkg.sv @@
// shared types and constants for the ray convex polygon clip block
package rcpc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int NORM_W = 16;
  localparam int PROD_W = 50;
  localparam int NUM_W = 51;
  localparam int QUO_STEPS = 64;

  typedef struct packed {
    logic start;
    logic [NUM_W-2:0] a;
    logic [NUM_W-2:0] b;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
    logic rem_nz;
    logic [31:0] q;
  } div_rsp_t;
endpackage

@@ rtl/core/rcpc_div.sv @@
// restoring divider: quotient of (a << FRAC_BITS) / b, one bit per cycle
module rcpc_div import rcpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int EXT_W = NUM_W - 1 + FRAC_BITS;

  logic [EXT_W-1:0] dividend;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-2:0] divisor;
  logic [31:0] quo;
  logic ovf;
  logic busy;
  logic done;
  logic [6:0] cnt;
  logic [NUM_W-1:0] shifted;
  logic ge;

  assign shifted = {rem[NUM_W-2:0], dividend[EXT_W-1]};
  assign ge = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 7'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'(EXT_W);
        dividend <= {req.a, {FRAC_BITS{1'b0}}};
        divisor <= req.b;
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
      end else if (busy) begin
        dividend <= {dividend[EXT_W-2:0], 1'b0};
        rem <= ge ? shifted - {1'b0, divisor} : shifted;
        if (ge && cnt > 7'd32) ovf <= 1'b1;
        quo <= {quo[30:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf = ovf;
  assign rsp.q = quo;
  assign rsp.rem_nz = rem != '0;
endmodule

@@ rtl/core/ray_convex_polygon_clip.sv @@
// ray convex polygon clip top level: sequencer, shared multiplier and divider
// an edge runs the multiply states and, with a division, waits on the
// bit-serial divider (66 steps); an edge of a rejected query skips them; the
// last edge adds the hit point and output load (only the load when rejected);
// one word at a time, ready only in idle; the output register frees the input
// side as soon as a result is loaded; synchronous active-high reset clears the state, bounds, flags and valid
module ray_convex_polygon_clip import rcpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ray_start_x, ray_start_y, ray_end_x, ray_end_y, max_fraction,
  // edge_normal_x, edge_normal_y, edge_vertex_x, edge_vertex_y, first_edge
  input  logic [263:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_flag, hit_fraction, hit_normal_x, hit_normal_y, hit_point_x, hit_point_y
  output logic [135:0] m_tdata
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_MUL0 = 8'b00000010, S_MUL1 = 8'b00000100,
    S_MUL2 = 8'b00001000, S_MUL3 = 8'b00010000, S_DIV = 8'b00100000,
    S_LERP = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state;
  logic signed [31:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
  logic [31:0] lower_bound, upper_bound;
  logic signed [15:0] entry_normal_x, entry_normal_y, nx, ny;
  logic signed [31:0] vx, vy;
  logic entry_found, query_rejected, last;
  logic signed [NUM_W-1:0] num;
  logic [2:0] step;

  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [66:0] prod;
  logic signed [33:0] dx, dy;
  logic signed [65:0] acc;

  div_req_t dreq;
  div_rsp_t drsp;
  logic entering;

  rcpc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_tready = (state == S_IDLE);
  assign mul_p = mul_a * mul_b;
  assign dx = 34'(end_x_reg) - 34'(start_x_reg);
  assign dy = 34'(end_y_reg) - 34'(start_y_reg);

  function automatic logic signed [65:0] floor_sh(input logic signed [66:0] x);
    floor_sh = 66'(x >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] sat(input logic signed [65:0] r);
    if (r > 66'sd2147483647) sat = 32'h7fffffff;
    else if (r < -66'sd2147483648) sat = 32'h80000000;
    else sat = r[31:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      3'd0: begin mul_a = 33'(nx); mul_b = 34'(vx) - 34'(start_x_reg); end
      3'd1: begin mul_a = 33'(ny); mul_b = 34'(vy) - 34'(start_y_reg); end
      3'd2: begin mul_a = 33'(nx); mul_b = dx; end
      3'd3: begin mul_a = 33'(ny); mul_b = dy; end
      3'd4: begin mul_a = 33'({1'b0, lower_bound[31:FRAC_BITS]}); mul_b = dx; end
      3'd5: begin mul_a = 33'({1'b0, lower_bound[FRAC_BITS-1:0]}); mul_b = dx; end
      3'd6: begin mul_a = 33'({1'b0, lower_bound[31:FRAC_BITS]}); mul_b = dy; end
      3'd7: begin mul_a = 33'({1'b0, lower_bound[FRAC_BITS-1:0]}); mul_b = dy; end
      default: ;
    endcase
  end

  logic [31:0] pt_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      start_x_reg <= '0; start_y_reg <= '0; end_x_reg <= '0; end_y_reg <= '0;
      lower_bound <= '0; upper_bound <= '0;
      entry_normal_x <= '0; entry_normal_y <= '0;
      entry_found <= 1'b0; query_rejected <= 1'b0;
      dreq.start <= 1'b0;
      step <= '0;
    end else begin
      if (state != S_MUL3) dreq.start <= 1'b0;
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) begin
          nx <= s_tdata[175:160];
          ny <= s_tdata[191:176];
          vx <= s_tdata[223:192];
          vy <= s_tdata[255:224];
          last <= s_tlast;
          if (s_tdata[256]) begin
            start_x_reg <= s_tdata[31:0];
            start_y_reg <= s_tdata[63:32];
            end_x_reg <= s_tdata[95:64];
            end_y_reg <= s_tdata[127:96];
            upper_bound <= s_tdata[159:128];
            lower_bound <= '0;
            entry_normal_x <= '0; entry_normal_y <= '0;
            entry_found <= 1'b0; query_rejected <= 1'b0;
            state <= S_MUL0;
          end else begin
            state <= query_rejected ? (s_tlast ? S_OUT : S_IDLE) : S_MUL0;
          end
          step <= 3'd0;
        end
        S_MUL0: begin prod <= mul_p; step <= 3'd1; state <= S_MUL1; end
        S_MUL1: begin num <= NUM_W'(prod + mul_p); step <= 3'd2; state <= S_MUL2; end
        S_MUL2: begin prod <= mul_p; step <= 3'd3; state <= S_MUL3; end
        S_MUL3: begin
          if (NUM_W'(prod + mul_p) == '0) begin
            if (num < 0) query_rejected <= 1'b1;
            else if (upper_bound < lower_bound) query_rejected <= 1'b1;
            state <= last ? S_LERP : S_IDLE;
          end else if (NUM_W'(prod + mul_p) < 0) begin
            if (num < 0) begin
              entering <= 1'b1;
              dreq.start <= 1'b1;
              dreq.a <= (NUM_W-1)'(-num);
              dreq.b <= (NUM_W-1)'(-(prod + mul_p));
              state <= S_DIV;
            end else begin
              if (upper_bound < lower_bound) query_rejected <= 1'b1;
              state <= last ? S_LERP : S_IDLE;
            end
          end else begin
            if (num < 0) begin
              query_rejected <= 1'b1;
              state <= last ? S_LERP : S_IDLE;
            end else begin
              entering <= 1'b0;
              dreq.start <= 1'b1;
              dreq.a <= (NUM_W-1)'(num);
              dreq.b <= (NUM_W-1)'(prod + mul_p);
              state <= S_DIV;
            end
          end
          step <= 3'd4;
        end
        S_DIV: if (drsp.done) begin
          state <= last ? S_LERP : S_IDLE;
          if (entering) begin
            if (drsp.ovf) query_rejected <= 1'b1;
            else if (drsp.q > lower_bound || (drsp.q == lower_bound && drsp.rem_nz)) begin
              lower_bound <= drsp.q;
              entry_normal_x <= nx; entry_normal_y <= ny;
              entry_found <= 1'b1;
              if (upper_bound < drsp.q) query_rejected <= 1'b1;
            end else if (upper_bound < lower_bound) query_rejected <= 1'b1;
          end else begin
            if (!drsp.ovf && drsp.q < upper_bound) begin
              upper_bound <= drsp.q;
              if (drsp.q < lower_bound) query_rejected <= 1'b1;
            end else if (upper_bound < lower_bound) query_rejected <= 1'b1;
          end
        end
        S_LERP: begin
          step <= step + 3'd1;
          case (step)
            3'd4, 3'd6: prod <= mul_p;
            3'd5: pt_x <= sat(66'(start_x_reg) + 66'(prod) + floor_sh(mul_p));
            3'd7: begin
              acc <= 66'(start_y_reg) + 66'(prod) + floor_sh(mul_p);
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          if (!query_rejected && entry_found) begin
            m_tdata <= {7'd0, sat(acc), pt_x, entry_normal_y, entry_normal_x,
                        lower_bound, 1'b1};
          end else begin
            m_tdata <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !s_tready) else $error("ready while dividing");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed while waiting");
endmodule
